FILE: hw/rtl/mbps_pkg.sv
`default_nettype none
package mbps_pkg;

  localparam int PAT_MAX_BYTES = 16;
  localparam int WIN_BITS      = PAT_MAX_BYTES * 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int ADDR_W        = 6;
  localparam int REG_IDX_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASK_LOW     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK_HIGH    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LENGTH   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEP_SIZE    = 3'd5;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [63:0] mask_low;
    logic [63:0] mask_high;
    logic [4:0]  pattern_length;
    logic [3:0]  step_size;
  } cfg_t;

  // one candidate match position, handed from front to back
  typedef struct packed {
    logic [WIN_BITS-1:0] window;   // byte 0 is the newest
    logic [63:0]         start;
    logic [63:0]         base;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mbps_in_if.sv
`default_nettype none
interface mbps_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_segment;
  logic [63:0] segment_rva;

  modport source (output valid, data_byte, first_of_segment, segment_rva, input ready);
  modport sink   (input valid, data_byte, first_of_segment, segment_rva, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mbps_out_if.sv
`default_nettype none
interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] match_rva;

  modport source (output valid, match_rva, input ready);
  modport sink   (input valid, match_rva, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/masked_byte_pattern_scanner.sv
`default_nettype none
// Scans a byte stream, one byte per beat, for a masked pattern of up to 16 bytes
// and gives the address (segment base plus start offset) of each match once its
// last byte has arrived. A beat with first_of_segment set restarts the offset
// and takes segment_rva as the new base. One byte is taken every cycle unless
// the queue is full; the front tracks the window and offset, a two-entry queue
// feeds the back, which does the 16-byte masked compare and the 64-bit address
// add into the output register, so a match passes through the queue and then
// the output register. Registers are at byte address 8*i over a 64-bit APB data
// path and should be written only while the scanner is idle.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  mbps_in_if.sink                in_ch,
  mbps_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [ADDR_W-1:0] cfg_paddr,
  input  wire logic [63:0]       cfg_pwdata,
  output logic [63:0]            cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t      cfg;
  q_entry_t  push_entry, head;
  q_status_t q_status;
  logic      push, pop, in_beat;

  assign in_ch.ready = !q_status.full;
  assign in_beat     = in_ch.valid && in_ch.ready;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mbps_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .beat             (in_beat),
    .data_byte        (in_ch.data_byte),
    .first_of_segment (in_ch.first_of_segment),
    .segment_rva      (in_ch.segment_rva),
    .push             (push),
    .push_entry       (push_entry)
  );

  mbps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  mbps_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_match_rva (out_ch.match_rva)
  );

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !in_ch.ready)
    else $error("input taken while queue full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.empty |-> !pop)
    else $error("pop from empty queue");

  a_zero_len_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg.pattern_length == 5'd0) |-> !push)
    else $error("candidate queued with zero pattern length");

  a_push_full_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_status.empty && !pop) |=> !q_status.empty)
    else $error("queued candidate lost");

endmodule
`default_nettype wire

FILE: hw/rtl/mbps_cfg.sv
`default_nettype none
module mbps_cfg
  import mbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_PATTERN_LOW:  cfg_nxt.pattern_low    = pwdata;
        REG_PATTERN_HIGH: cfg_nxt.pattern_high   = pwdata;
        REG_MASK_LOW:     cfg_nxt.mask_low       = pwdata;
        REG_MASK_HIGH:    cfg_nxt.mask_high      = pwdata;
        REG_PAT_LENGTH:   cfg_nxt.pattern_length = pwdata[4:0];
        REG_STEP_SIZE:    cfg_nxt.step_size      = pwdata[3:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PATTERN_LOW:  prdata = cfg_r.pattern_low;
      REG_PATTERN_HIGH: prdata = cfg_r.pattern_high;
      REG_MASK_LOW:     prdata = cfg_r.mask_low;
      REG_MASK_HIGH:    prdata = cfg_r.mask_high;
      REG_PAT_LENGTH:   prdata = {59'd0, cfg_r.pattern_length};
      REG_STEP_SIZE:    prdata = {60'd0, cfg_r.step_size};
      default:          prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= 64'd0;
      cfg_r.pattern_high   <= 64'd0;
      cfg_r.mask_low       <= '1;
      cfg_r.mask_high      <= '1;
      cfg_r.pattern_length <= 5'd1;
      cfg_r.step_size      <= 4'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mbps_front.sv
`default_nettype none
module mbps_front
  import mbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        beat,        // input item accepted this cycle
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_of_segment,
  input  wire logic [63:0] segment_rva,
  output logic             push,
  output q_entry_t         push_entry
);

  logic [WIN_BITS-1:0] window_r, window_nxt;
  logic [63:0]         offset_r, offset_nxt;
  logic [63:0]         base_r, base_nxt;
  logic [63:0]         cur;
  logic [63:0]         len_m1;
  logic [63:0]         start;
  logic [4:0]          len;
  logic [3:0]          step;
  logic [2:0]          smask;
  logic                len_ok, step_ok, div_ok, long_enough, aligned, step_big;

  assign len  = cfg.pattern_length;
  assign step = cfg.step_size;

  always_comb begin
    if (first_of_segment) begin
      window_nxt = {{(WIN_BITS-8){1'b0}}, data_byte};
      cur        = 64'd0;
      base_nxt   = segment_rva;
    end else begin
      window_nxt = {window_r[WIN_BITS-9:0], data_byte};
      cur        = offset_r;
      base_nxt   = base_r;
    end
    offset_nxt = cur + 64'd1;
  end

  assign len_ok   = (len != 5'd0) && (len <= 5'(PAT_MAX_BYTES));
  assign step_ok  = (step == 4'd0) || (step == 4'd1) || (step == 4'd2) ||
                    (step == 4'd4) || (step == 4'd8);
  assign step_big = step > 4'd1;
  assign smask    = 3'(step - 4'd1);
  assign div_ok   = !step_big || ((len[2:0] & smask) == 3'd0);

  assign len_m1      = {59'd0, 5'(len - 5'd1)};
  assign long_enough = cur >= len_m1;
  assign start       = cur - len_m1;
  assign aligned     = !step_big || ((start[2:0] & smask) == 3'd0);

  assign push              = beat && len_ok && step_ok && div_ok && long_enough && aligned;
  assign push_entry.window = window_nxt;
  assign push_entry.start  = start;
  assign push_entry.base   = base_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      offset_r <= 64'd0;
      base_r   <= 64'd0;
    end else if (beat) begin
      window_r <= window_nxt;
      offset_r <= offset_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mbps_queue.sv
`default_nettype none
module mbps_queue
  import mbps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_status_t     status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign status.full  = count_r == CNT_W'(QUEUE_DEPTH);
  assign status.empty = count_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mbps_back.sv
`default_nettype none
module mbps_back
  import mbps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire q_entry_t    head,
  input  wire q_status_t   q_status,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_match_rva
);

  logic [WIN_BITS-1:0] pat, msk;
  logic [PAT_MAX_BYTES-1:0] byte_ok;
  logic [4:0]  len;
  logic [3:0]  widx;
  logic [7:0]  d, m, p;
  logic        hit, slot_free, load;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] rva_r;

  assign len = cfg.pattern_length;
  assign pat = {cfg.pattern_high, cfg.pattern_low};
  assign msk = {cfg.mask_high, cfg.mask_low};

  // pattern byte i lines up with the window byte that came len-1-i beats ago
  always_comb begin
    for (int i = 0; i < PAT_MAX_BYTES; i++) begin
      widx = 4'(len - 5'd1 - 5'(i));
      d    = head.window[widx*8 +: 8];
      m    = msk[i*8 +: 8];
      p    = pat[i*8 +: 8];
      byte_ok[i] = (5'(i) >= len) || ((d & m) == (p & m));
    end
  end

  assign hit       = &byte_ok;
  assign slot_free = !out_valid_r || out_ready;
  assign pop       = !q_status.empty && (!hit || slot_free);
  assign load      = !q_status.empty && hit && slot_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rva_r <= head.base + head.start;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_match_rva = rva_r;

endmodule
`default_nettype wire
